@@ sv/softmax_forward_backward_unit_macros.svh @@
// assertion macros shared by the checker of the softmax unit
// include-guarded; no dependencies
`ifndef SOFTMAX_FORWARD_BACKWARD_UNIT_MACROS_SVH
`define SOFTMAX_FORWARD_BACKWARD_UNIT_MACROS_SVH

// same-cycle implication, disabled in reset
`define SFB_ASSERT_NOW(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("softmax unit check failed");

// next-cycle implication, disabled in reset
`define SFB_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("softmax unit check failed");

`endif

@@ sv/sfb_pkg.sv @@
// shared types, constants and tables of the softmax forward/backward unit
// no dependencies
package sfb_pkg;

  localparam int MAX_LENGTH_DEF = 64;
  localparam int VL_W           = 7;
  localparam logic [VL_W-1:0] VL_RESET = 7'd64;
  localparam int ACC_W          = 40;
  localparam int DIV_STEPS      = 17;
  localparam logic [16:0] LOG2E_Q16 = 17'd94548;
  localparam logic [5:0] EXP_N_LIMIT = 6'd17;
  localparam logic REG_VECTOR_LENGTH = 1'b0;
  localparam logic OP_FORWARD  = 1'b0;
  localparam logic OP_BACKWARD = 1'b1;

  // 2^(-2^(k-16)) in Q16, entry k
  localparam logic [15:0] POW2_NEG [0:15] = '{
    16'd65535, 16'd65535, 16'd65533, 16'd65530, 16'd65525, 16'd65514, 16'd65492, 16'd65447,
    16'd65359, 16'd65182, 16'd64830, 16'd64132, 16'd62757, 16'd60097, 16'd55109, 16'd46341
  };

  typedef struct packed {
    logic              opcode;
    logic signed [15:0] value;
    logic [15:0]       saved_output;
  } sfb_in_t;

  typedef struct packed {
    logic [15:0]        probability;
    logic signed [15:0] gradient;
    logic               is_backward;
    logic               last_in_row;
  } sfb_out_t;

endpackage

@@ sv/sfb_ram.sv @@
// generic simple dual-port ram, one write and one registered read port
// no dependencies
module sfb_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

@@ sv/sfb_exp.sv @@
// fixed-point exp(-u) in Q1.16, one table step per cycle
// depends on sfb_pkg
module sfb_exp (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [15:0] u,
  output logic        done,
  output logic [16:0] e
);
  import sfb_pkg::*;

  typedef enum logic [2:0] {
    E_IDLE = 3'b001,
    E_RUN  = 3'b010,
    E_FIN  = 3'b100
  } exp_state_t;

  exp_state_t  state;
  logic [33:0] z_full;
  logic [15:0] f;
  logic [5:0]  n;
  logic [3:0]  k;
  logic [16:0] r;
  logic [33:0] r_mul;

  assign z_full = 34'(u) * 34'(LOG2E_Q16) + 34'd2048;
  assign r_mul  = 34'(r) * 34'(POW2_NEG[k]) + 34'd32768;
  assign done   = (state == E_FIN);
  assign e      = (n >= EXP_N_LIMIT) ? 17'd0 : (r >> n);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= E_IDLE;
    end else begin
      case (state)
        E_IDLE: begin
          if (start) begin
            f     <= z_full[27:12];
            n     <= z_full[33:28];
            k     <= 4'd15;
            r     <= 17'd65536;
            state <= E_RUN;
          end
        end
        E_RUN: begin
          // fraction bits taken from the top down
          if (f[k]) begin
            r <= r_mul[32:16];
          end
          k <= k - 4'd1;
          if (k == 4'd0) begin
            state <= E_FIN;
          end
        end
        E_FIN: begin
          state <= E_IDLE;
        end
        default: begin
          state <= E_IDLE;
        end
      endcase
    end
  end
endmodule

@@ sv/softmax_forward_backward_unit.sv @@
// Softmax with gradient. One element is taken per start while busy is low; after
// the last element of a row (vector_length elements, 0 read as 1 and values above
// MAX_LENGTH as MAX_LENGTH) busy stays high while the row is worked through and
// its results leave one per strobe, in element order, and cannot be held off. A
// backward row handles each element by memory read, multiply and round. A forward
// row makes two passes through the shared exp unit (16 table steps each) plus a
// 17-step restoring divider on the second. Elements live in two single-port-read
// memories; busy interlocks reads against writes. A vector_length write or an
// opcode change drops any partial row.
// depends on sfb_pkg, sfb_ram, sfb_exp
module softmax_forward_backward_unit #(
  parameter int MAX_LENGTH = sfb_pkg::MAX_LENGTH_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [2:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  input  logic              start,
  input  sfb_pkg::sfb_in_t  item,
  output logic              busy,
  output logic              result_valid,
  output sfb_pkg::sfb_out_t result
);
  import sfb_pkg::*;

  localparam int AW = $clog2(MAX_LENGTH);
  localparam int CW = $clog2(MAX_LENGTH + 1);
  localparam int SW = $clog2(MAX_LENGTH) + 17;

  typedef enum logic [7:0] {
    S_IDLE  = 8'b00000001,
    S_READ  = 8'b00000010,
    S_EXP   = 8'b00000100,
    S_WAIT  = 8'b00001000,
    S_DIV   = 8'b00010000,
    S_EMIT  = 8'b00100000,
    S_BMUL  = 8'b01000000,
    S_BEMIT = 8'b10000000
  } state_t;

  state_t                 state;
  logic [VL_W-1:0]        vector_length;
  logic [CW-1:0]          len;
  logic [CW-1:0]          count;
  logic                   row_mode;
  logic signed [15:0]     row_max;
  logic signed [ACC_W-1:0] acc;
  logic [SW-1:0]          sum;
  logic                   pass;
  logic [AW-1:0]          idx;

  logic                   accept;
  logic                   cfg_write;
  logic                   clr;
  logic [CW-1:0]          widx;
  logic [CW-1:0]          count_next;
  logic signed [15:0]     base_max;
  logic signed [ACC_W-1:0] base_acc;
  logic signed [32:0]     item_prod;
  logic                   is_last;

  logic [15:0]            val_q;
  logic [15:0]            aux_q;
  logic                   exp_start;
  logic                   exp_done;
  logic [16:0]            exp_e;
  logic [16:0]            u_diff;

  logic [33:0]            num_full;
  logic [16:0]            num_sh;
  logic [SW-1:0]          rem;
  logic [SW:0]            rem_sh;
  logic [16:0]            quo;
  logic [4:0]             div_cnt;

  logic signed [40:0]     gdiff;
  logic signed [57:0]     bprod;
  logic signed [57:0]     brnd;
  logic signed [25:0]     bq;
  logic signed [15:0]     bsat;
  logic [15:0]            psat;

  assign pready    = 1'b1;
  assign prdata    = 32'(vector_length);
  assign busy      = (state != S_IDLE);
  assign accept    = start && !busy;
  assign cfg_write = psel && penable && pwrite && pready && (paddr[2] == REG_VECTOR_LENGTH);

  always_comb begin
    if (vector_length == '0) begin
      len = CW'(1);
    end else if (vector_length > VL_W'(MAX_LENGTH)) begin
      len = CW'(MAX_LENGTH);
    end else begin
      len = CW'(vector_length);
    end
  end

  assign clr        = (count == '0) || (item.opcode != row_mode);
  assign widx       = clr ? '0 : count;
  assign count_next = widx + CW'(1);
  assign base_max   = clr ? 16'sh8000 : row_max;
  assign base_acc   = clr ? '0 : acc;
  assign item_prod  = item.value * $signed({1'b0, item.saved_output});
  assign is_last    = (CW'(idx) == count - CW'(1));

  sfb_ram #(.WIDTH(16), .DEPTH(MAX_LENGTH)) u_value_ram (
    .clk   (clk),
    .we    (accept),
    .waddr (widx[AW-1:0]),
    .wdata (item.value),
    .raddr (idx),
    .rdata (val_q)
  );

  sfb_ram #(.WIDTH(16), .DEPTH(MAX_LENGTH)) u_aux_ram (
    .clk   (clk),
    .we    (accept),
    .waddr (widx[AW-1:0]),
    .wdata (item.saved_output),
    .raddr (idx),
    .rdata (aux_q)
  );

  assign exp_start = (state == S_EXP);
  assign u_diff    = {row_max[15], row_max} - {val_q[15], val_q};

  sfb_exp u_exp (
    .clk   (clk),
    .rst   (rst),
    .start (exp_start),
    .u     (u_diff[15:0]),
    .done  (exp_done),
    .e     (exp_e)
  );

  // divider numerator e*65536 + sum/2
  assign num_full = {exp_e, 16'd0} + 34'(sum >> 1);
  assign rem_sh   = {rem, num_sh[16]};
  assign psat     = (sum == '0) ? 16'd0 : (quo[16] ? 16'hFFFF : quo[15:0]);

  assign gdiff = {{9{val_q[15]}}, val_q, 16'd0} - {acc[ACC_W-1], acc};
  assign brnd  = bprod + 58'sd2147483648;
  assign bq    = brnd[57:32];
  always_comb begin
    if (bq > 26'sd32767) begin
      bsat = 16'sh7FFF;
    end else if (bq < -26'sd32768) begin
      bsat = 16'sh8000;
    end else begin
      bsat = bq[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      vector_length <= VL_RESET;
      count         <= '0;
      row_mode      <= OP_FORWARD;
      row_max       <= 16'sh8000;
      acc           <= '0;
      sum           <= '0;
      pass          <= 1'b0;
      idx           <= '0;
      result_valid  <= 1'b0;
    end else begin
      result_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (cfg_write) begin
            vector_length <= pwdata[VL_W-1:0];
            count         <= '0;
            row_max       <= 16'sh8000;
            acc           <= '0;
          end else if (accept) begin
            row_mode <= item.opcode;
            count    <= count_next;
            if (item.opcode == OP_FORWARD) begin
              row_max <= (item.value > base_max) ? item.value : base_max;
              acc     <= base_acc;
            end else begin
              row_max <= base_max;
              acc     <= base_acc + ACC_W'(item_prod);
            end
            if (count_next >= len) begin
              idx   <= '0;
              pass  <= 1'b0;
              sum   <= '0;
              state <= S_READ;
            end
          end
        end
        S_READ: begin
          state <= (row_mode == OP_BACKWARD) ? S_BMUL : S_EXP;
        end
        S_EXP: begin
          state <= S_WAIT;
        end
        S_WAIT: begin
          if (exp_done) begin
            if (!pass) begin
              sum <= sum + SW'(exp_e);
              if (is_last) begin
                pass <= 1'b1;
                idx  <= '0;
              end else begin
                idx <= idx + AW'(1);
              end
              state <= S_READ;
            end else begin
              rem     <= SW'(num_full[33:17]);
              num_sh  <= num_full[16:0];
              div_cnt <= 5'(DIV_STEPS);
              state   <= S_DIV;
            end
          end
        end
        S_DIV: begin
          if (rem_sh >= {1'b0, sum}) begin
            rem <= SW'(rem_sh - {1'b0, sum});
            quo <= {quo[15:0], 1'b1};
          end else begin
            rem <= rem_sh[SW-1:0];
            quo <= {quo[15:0], 1'b0};
          end
          num_sh  <= {num_sh[15:0], 1'b0};
          div_cnt <= div_cnt - 5'd1;
          if (div_cnt == 5'd1) begin
            state <= S_EMIT;
          end
        end
        S_EMIT: begin
          result_valid       <= 1'b1;
          result.probability <= psat;
          result.gradient    <= '0;
          result.is_backward <= 1'b0;
          result.last_in_row <= is_last;
          if (is_last) begin
            count   <= '0;
            row_max <= 16'sh8000;
            acc     <= '0;
            state   <= S_IDLE;
          end else begin
            idx   <= idx + AW'(1);
            state <= S_READ;
          end
        end
        S_BMUL: begin
          bprod <= $signed({1'b0, aux_q}) * gdiff;
          state <= S_BEMIT;
        end
        S_BEMIT: begin
          result_valid       <= 1'b1;
          result.probability <= '0;
          result.gradient    <= bsat;
          result.is_backward <= 1'b1;
          result.last_in_row <= is_last;
          if (is_last) begin
            count   <= '0;
            row_max <= 16'sh8000;
            acc     <= '0;
            state   <= S_IDLE;
          end else begin
            idx   <= idx + AW'(1);
            state <= S_READ;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end
endmodule

@@ sv/sfb_checker.sv @@
// port-level checks on the softmax unit, bound to the top level
// depends on sfb_pkg and softmax_forward_backward_unit_macros.svh
`include "softmax_forward_backward_unit_macros.svh"

module sfb_checker (
  input logic              clk,
  input logic              rst,
  input logic              start,
  input logic              busy,
  input logic              result_valid,
  input sfb_pkg::sfb_out_t result
);
  import sfb_pkg::*;

  logic mode_ok;

  // the unused output of each mode reads zero
  assign mode_ok = (!result.is_backward || result.probability == 16'd0) &&
                   (result.is_backward || result.gradient == 16'sd0);

  // a row keeps the block busy until its final transfer
  `SFB_ASSERT_NOW(a_busy_mid_row, clk, rst, result_valid && !result.last_in_row, busy)
  `SFB_ASSERT_NOW(a_idle_at_row_end, clk, rst, result_valid && result.last_in_row, !busy)
  `SFB_ASSERT_NOW(a_mode_zero, clk, rst, result_valid, mode_ok)
  `SFB_ASSERT_NEXT(a_no_result_after_load, clk, rst, start && !busy, !result_valid)
endmodule

bind softmax_forward_backward_unit sfb_checker u_sfb_checker (
  .clk          (clk),
  .rst          (rst),
  .start        (start),
  .busy         (busy),
  .result_valid (result_valid),
  .result       (result)
);
